/* hw/rtl/cpc_pkg.sv */
// shared types, codes and constants of the command packet checker
`timescale 1ns / 1ps
package cpc_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int RESP_W    = 3;
  localparam int ACT_W     = 4;
  localparam int CFG_IDX_W = 8;
  localparam int HDR_BYTES = 5;
  localparam int HDR_BITS  = HDR_BYTES * BYTE_W;
  localparam int MSG_BITS  = HDR_BITS + WORD_W;
  localparam int CNT_W     = $clog2(MSG_BITS);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [MSG_BITS-1:0] crc_tbl_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = CFG_IDX_W'(1);

  localparam byte_t DEVICE_ID_RESET = 8'h00;
  localparam byte_t CRC_POLY_RESET  = 8'h89;

  // command classes and codes
  localparam byte_t CLS_SET  = 8'h01;
  localparam byte_t CLS_LAMP = 8'h02;
  localparam byte_t CLS_READ = 8'h03;

  localparam byte_t CODE_A = 8'h0A;
  localparam byte_t CODE_B = 8'h0B;
  localparam byte_t CODE_C = 8'h0C;
  localparam byte_t CODE_D = 8'h0D;
  localparam byte_t CODE_E = 8'h0E;

  // required length bytes
  localparam byte_t LEN_NONE = 8'h00;
  localparam byte_t LEN_DATA = 8'h04;
  localparam byte_t LEN_TEMP = 8'h04;
  localparam byte_t LEN_AXES = 8'h0C;
  localparam byte_t LEN_ALL  = 8'h28;

  // response codes
  localparam logic [RESP_W-1:0] RESP_ACK       = 3'd0;
  localparam logic [RESP_W-1:0] RESP_CRC_ERR   = 3'd1;
  localparam logic [RESP_W-1:0] RESP_LEN_ERR   = 3'd2;
  localparam logic [RESP_W-1:0] RESP_CLASS_ERR = 3'd3;
  localparam logic [RESP_W-1:0] RESP_CODE_ERR  = 3'd4;

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_SET_POS   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_SET_NEG   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_SET_ANGLE = 4'd3;
  localparam logic [ACT_W-1:0] ACT_LAMP_ON   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_LAMP_OFF  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SEND_GYRO = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SEND_ACC  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_SEND_TEMP = 4'd8;
  localparam logic [ACT_W-1:0] ACT_SEND_ANG  = 4'd9;
  localparam logic [ACT_W-1:0] ACT_SEND_ALL  = 4'd10;

  typedef struct packed {
    logic             class_ok;
    logic             code_ok;
    logic             carries_word;
    byte_t            need_high;
    byte_t            need_low;
    logic [ACT_W-1:0] act;
  } cmd_info_t;

  typedef struct packed {
    byte_t             cmd_class;
    byte_t             cmd_code;
    byte_t             len_high;
    byte_t             len_low;
    logic [WORD_W-1:0] data_word;
    byte_t             rx_crc;
  } pkt_t;

  typedef struct packed {
    logic [RESP_W-1:0] response_code;
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] payload_word;
  } result_t;

endpackage

/* hw/rtl/cpc_crc_table.sv */
// residue table of the crc: x^(8+d) mod poly for every bit distance d, built by a shift sweep
`timescale 1ns / 1ps
module cpc_crc_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  cpc_pkg::byte_t   seed_i,
  output logic             busy_o,
  output cpc_pkg::crc_tbl_t tbl_o
);
  import cpc_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(MSG_BITS - 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  byte_t            cur_r, cur_nxt;
  byte_t            poly_r, poly_nxt;
  crc_tbl_t         tbl_r, tbl_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    cur_nxt  = cur_r;
    poly_nxt = poly_r;
    tbl_nxt  = tbl_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      cur_nxt  = seed_i;
      poly_nxt = seed_i;
    end else if (busy_r) begin
      // newest residue enters at the far end, so entry d ends up as distance d
      tbl_nxt = {cur_r, tbl_r[MSG_BITS-1:1]};
      cur_nxt = {cur_r[BYTE_W-2:0], 1'b0} ^ (cur_r[BYTE_W-1] ? poly_r : '0);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      cur_r  <= CRC_POLY_RESET;
      poly_r <= CRC_POLY_RESET;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      cur_r  <= cur_nxt;
      poly_r <= poly_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tbl_r <= tbl_nxt;
  end

  assign busy_o = busy_r;
  assign tbl_o  = tbl_r;

  a_sweep_runs: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != LAST && !start_i |=> busy_r)
    else $error("sweep stopped early");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST)
    else $error("sweep count out of range");

  a_table_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !start_i |=> !busy_r && $stable(tbl_r))
    else $error("table changed while idle");

endmodule

/* hw/rtl/cpc_decode.sv */
// command table: class and code to required length bytes and action
`timescale 1ns / 1ps
module cpc_decode (
  input  cpc_pkg::byte_t    cmd_class_i,
  input  cpc_pkg::byte_t    cmd_code_i,
  output cpc_pkg::cmd_info_t info_o
);
  import cpc_pkg::*;

  always_comb begin
    info_o           = '0;
    info_o.class_ok  = 1'b1;
    info_o.code_ok   = 1'b1;
    info_o.need_high = LEN_NONE;
    info_o.need_low  = LEN_NONE;
    info_o.act       = ACT_NONE;
    case (cmd_class_i)
      CLS_SET: begin
        info_o.need_low     = LEN_DATA;
        info_o.carries_word = 1'b1;
        case (cmd_code_i)
          CODE_A:  info_o.act = ACT_SET_POS;
          CODE_B:  info_o.act = ACT_SET_NEG;
          CODE_C:  info_o.act = ACT_SET_ANGLE;
          default: info_o.code_ok = 1'b0;
        endcase
      end
      CLS_LAMP: begin
        case (cmd_code_i)
          CODE_A:  info_o.act = ACT_LAMP_ON;
          CODE_B:  info_o.act = ACT_LAMP_OFF;
          default: info_o.code_ok = 1'b0;
        endcase
      end
      CLS_READ: begin
        case (cmd_code_i)
          CODE_A: begin
            info_o.act       = ACT_SEND_GYRO;
            info_o.need_high = LEN_AXES;
          end
          CODE_B: begin
            info_o.act       = ACT_SEND_ACC;
            info_o.need_high = LEN_AXES;
          end
          CODE_C: begin
            info_o.act       = ACT_SEND_TEMP;
            info_o.need_high = LEN_TEMP;
          end
          CODE_D: begin
            info_o.act       = ACT_SEND_ANG;
            info_o.need_high = LEN_AXES;
          end
          CODE_E: begin
            info_o.act       = ACT_SEND_ALL;
            info_o.need_high = LEN_ALL;
          end
          default: info_o.code_ok = 1'b0;
        endcase
      end
      default: info_o.class_ok = 1'b0;
    endcase
  end

endmodule

/* hw/rtl/cpc_crc_fold.sv */
// crc of a packet as an xor tree over the residues of its set bits
`timescale 1ns / 1ps
module cpc_crc_fold (
  input  cpc_pkg::crc_tbl_t        tbl_i,
  input  logic [cpc_pkg::MSG_BITS-1:0] msg_i,
  output cpc_pkg::byte_t           crc_o
);
  import cpc_pkg::*;

  logic [BYTE_W-1:0][MSG_BITS-1:0] col;

  always_comb begin
    for (int b = 0; b < BYTE_W; b++) begin
      for (int j = 0; j < MSG_BITS; j++) begin
        col[b][j] = tbl_i[j][b];
      end
      crc_o[b] = ^(col[b] & msg_i);
    end
  end

endmodule

/* hw/rtl/command_packet_checker_top.sv */
// top level of the command packet checker: input stage, check logic, result stage
//
//  channel | signals                                  | direction
//  in      | in_valid, in_ready, in_<field>           | item in
//  out     | out_valid, out_ready, out_<field>        | item out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
// one item per cycle while in_ready is high; items move from input stage to result stage
// check path: decode, length compare and a 72-term xor tree on a table of crc residues
// after reset and after each crc_poly write the table is rebuilt, with in_ready held low
// out_ready low with a result waiting holds the result and input stages, no item is dropped
`timescale 1ns / 1ps
module command_packet_checker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cpc_pkg::byte_t                   in_cmd_class,
  input  cpc_pkg::byte_t                   in_cmd_code,
  input  cpc_pkg::byte_t                   in_len_high,
  input  cpc_pkg::byte_t                   in_len_low,
  input  logic [cpc_pkg::WORD_W-1:0]       in_data_word,
  input  cpc_pkg::byte_t                   in_rx_crc,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cpc_pkg::RESP_W-1:0]       out_response_code,
  output logic [cpc_pkg::ACT_W-1:0]        out_action,
  output logic [cpc_pkg::WORD_W-1:0]       out_payload_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  cpc_pkg::byte_t                   cfg_data
);
  import cpc_pkg::*;

  logic      s1_v_r, s1_v_nxt;
  logic      out_v_r, out_v_nxt;
  pkt_t      s1_r, s1_nxt;
  result_t   res_r, res_nxt;
  byte_t     device_id_r, device_id_nxt;

  logic      in_acc, cfg_acc, out_go, s1_go;
  logic      tbl_start, tbl_busy;
  crc_tbl_t  tbl;
  cmd_info_t info;
  logic [MSG_BITS-1:0] msg;
  byte_t     crc;
  result_t   res_calc;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign tbl_start = cfg_acc && (cfg_index == REG_CRC_POLY);
  assign device_id_nxt = (cfg_acc && cfg_index == REG_DEVICE_ID) ? cfg_data : device_id_r;

  cpc_crc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (tbl_start),
    .seed_i  (cfg_data),
    .busy_o  (tbl_busy),
    .tbl_o   (tbl)
  );

  // handshake
  assign out_go   = !out_v_r || out_ready;
  assign s1_go    = s1_v_r && out_go;
  assign in_ready = !tbl_busy && (!s1_v_r || out_go);
  assign in_acc   = in_valid && in_ready;

  assign s1_v_nxt  = in_acc || (s1_v_r && !out_go);
  assign out_v_nxt = s1_go || (out_v_r && !out_ready);

  always_comb begin
    s1_nxt = s1_r;
    if (in_acc) begin
      s1_nxt.cmd_class = in_cmd_class;
      s1_nxt.cmd_code  = in_cmd_code;
      s1_nxt.len_high  = in_len_high;
      s1_nxt.len_low   = in_len_low;
      s1_nxt.data_word = in_data_word;
      s1_nxt.rx_crc    = in_rx_crc;
    end
  end

  // check logic
  cpc_decode u_decode (
    .cmd_class_i (s1_r.cmd_class),
    .cmd_code_i  (s1_r.cmd_code),
    .info_o      (info)
  );

  always_comb begin
    if (s1_r.len_low == LEN_DATA) begin
      msg = {device_id_r, s1_r.cmd_class, s1_r.cmd_code, s1_r.len_high, s1_r.len_low,
             s1_r.data_word};
    end else begin
      msg = {{WORD_W{1'b0}}, device_id_r, s1_r.cmd_class, s1_r.cmd_code, s1_r.len_high,
             s1_r.len_low};
    end
  end

  cpc_crc_fold u_fold (
    .tbl_i (tbl),
    .msg_i (msg),
    .crc_o (crc)
  );

  always_comb begin
    res_calc.response_code = RESP_ACK;
    res_calc.action        = ACT_NONE;
    res_calc.payload_word  = '0;
    if (!info.class_ok) begin
      res_calc.response_code = RESP_CLASS_ERR;
    end else if (!info.code_ok) begin
      res_calc.response_code = RESP_CODE_ERR;
    end else if (s1_r.len_high != info.need_high || s1_r.len_low != info.need_low) begin
      res_calc.response_code = RESP_LEN_ERR;
    end else if (crc != s1_r.rx_crc) begin
      res_calc.response_code = RESP_CRC_ERR;
    end else begin
      res_calc.action = info.act;
      if (info.carries_word) begin
        res_calc.payload_word = s1_r.data_word;
      end
    end
  end

  assign res_nxt = s1_go ? res_calc : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      device_id_r <= DEVICE_ID_RESET;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_v_r     <= out_v_nxt;
      device_id_r <= device_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    res_r <= res_nxt;
  end

  assign out_valid         = out_v_r;
  assign out_response_code = res_r.response_code;
  assign out_action        = res_r.action;
  assign out_payload_word  = res_r.payload_word;

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> !in_ready)
    else $error("item accepted while crc table rebuilds");

  a_poly_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_start |=> !in_ready)
    else $error("input open right after a polynomial write");

  a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.response_code != RESP_ACK |->
      res_r.action == ACT_NONE && res_r.payload_word == '0)
    else $error("error result carries an action or payload");

  a_word_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.action != ACT_SET_POS && res_r.action != ACT_SET_NEG &&
      res_r.action != ACT_SET_ANGLE |-> res_r.payload_word == '0)
    else $error("payload on a command without data");

endmodule

/* sim/tb_command_packet_checker_top.sv */
// testbench of the command packet checker: directed and random packets and register settings against a predictor
`timescale 1ns / 1ps
module tb_command_packet_checker_top;
  import cpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

  class packet_scoreboard;
    byte_t   dev_id;
    byte_t   poly;
    result_t expected_q[$];
    int      fails;

    function new();
      dev_id = DEVICE_ID_RESET;
      poly   = CRC_POLY_RESET;
      fails  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, byte_t val);
      if (idx == REG_DEVICE_ID) dev_id = val;
      else if (idx == REG_CRC_POLY) poly = val;
    endfunction

    function byte_t crc_byte(byte_t crc, byte_t b);
      byte_t c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? (byte_t'(c << 1) ^ poly) : byte_t'(c << 1);
      end
      return c;
    endfunction

    function byte_t packet_crc(pkt_t p);
      byte_t c;
      c = crc_byte(8'h00, dev_id);
      c = crc_byte(c, p.cmd_class);
      c = crc_byte(c, p.cmd_code);
      c = crc_byte(c, p.len_high);
      c = crc_byte(c, p.len_low);
      if (p.len_low == LEN_DATA) begin
        for (int i = 3; i >= 0; i--) c = crc_byte(c, p.data_word[i*8 +: 8]);
      end
      return c;
    endfunction

    function result_t predict(pkt_t p);
      result_t           r;
      logic [RESP_W-1:0] resp;
      logic [ACT_W-1:0]  want;
      byte_t             need_h;
      byte_t             need_l;
      resp   = RESP_ACK;
      want   = ACT_NONE;
      need_h = LEN_NONE;
      need_l = LEN_NONE;
      case (p.cmd_class)
        CLS_SET: begin
          need_l = LEN_DATA;
          case (p.cmd_code)
            CODE_A: want = ACT_SET_POS;
            CODE_B: want = ACT_SET_NEG;
            CODE_C: want = ACT_SET_ANGLE;
            default: resp = RESP_CODE_ERR;
          endcase
        end
        CLS_LAMP: begin
          case (p.cmd_code)
            CODE_A: want = ACT_LAMP_ON;
            CODE_B: want = ACT_LAMP_OFF;
            default: resp = RESP_CODE_ERR;
          endcase
        end
        CLS_READ: begin
          case (p.cmd_code)
            CODE_A: begin
              want = ACT_SEND_GYRO;
              need_h = LEN_AXES;
            end
            CODE_B: begin
              want = ACT_SEND_ACC;
              need_h = LEN_AXES;
            end
            CODE_C: begin
              want = ACT_SEND_TEMP;
              need_h = LEN_TEMP;
            end
            CODE_D: begin
              want = ACT_SEND_ANG;
              need_h = LEN_AXES;
            end
            CODE_E: begin
              want = ACT_SEND_ALL;
              need_h = LEN_ALL;
            end
            default: resp = RESP_CODE_ERR;
          endcase
        end
        default: resp = RESP_CLASS_ERR;
      endcase
      if (resp == RESP_ACK) begin
        if (p.len_high != need_h || p.len_low != need_l) resp = RESP_LEN_ERR;
        else if (packet_crc(p) != p.rx_crc) resp = RESP_CRC_ERR;
      end
      r.response_code = resp;
      r.action        = (resp == RESP_ACK) ? want : ACT_NONE;
      r.payload_word  = (resp == RESP_ACK && want >= ACT_SET_POS && want <= ACT_SET_ANGLE) ?
                        p.data_word : '0;
      return r;
    endfunction

    function void note_input(pkt_t p);
      expected_q.push_back(predict(p));
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 100) $display("mismatch: %s", msg);
    endtask

    task check(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result resp %0d action %0d",
                         got.response_code, got.action));
        return;
      end
      want = expected_q.pop_front();
      if (got.response_code !== want.response_code)
        report($sformatf("response_code got %0d want %0d",
                         got.response_code, want.response_code));
      if (got.action !== want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.payload_word !== want.payload_word)
        report($sformatf("payload_word got %h want %h", got.payload_word, want.payload_word));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  byte_t                 in_cmd_class;
  byte_t                 in_cmd_code;
  byte_t                 in_len_high;
  byte_t                 in_len_low;
  logic [WORD_W-1:0]     in_data_word;
  byte_t                 in_rx_crc;
  logic                  out_valid;
  logic                  out_ready;
  logic [RESP_W-1:0]     out_response_code;
  logic [ACT_W-1:0]      out_action;
  logic [WORD_W-1:0]     out_payload_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  byte_t                 cfg_data;

  packet_scoreboard sb = new();
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int cycle_cnt = 0;

  command_packet_checker_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd_class      (in_cmd_class),
    .in_cmd_code       (in_cmd_code),
    .in_len_high       (in_len_high),
    .in_len_low        (in_len_low),
    .in_data_word      (in_data_word),
    .in_rx_crc         (in_rx_crc),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_response_code (out_response_code),
    .out_action        (out_action),
    .out_payload_word  (out_payload_word),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: checks accepted results, random stalls and the long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check(result_t'{out_response_code, out_action, out_payload_word});
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 25);
      end
    end
  end

  function automatic pkt_t cmd_frame(input int sel);
    pkt_t p;
    p = '0;
    case (sel)
      0: begin p.cmd_class = CLS_SET;  p.cmd_code = CODE_A; p.len_low = LEN_DATA; end
      1: begin p.cmd_class = CLS_SET;  p.cmd_code = CODE_B; p.len_low = LEN_DATA; end
      2: begin p.cmd_class = CLS_SET;  p.cmd_code = CODE_C; p.len_low = LEN_DATA; end
      3: begin p.cmd_class = CLS_LAMP; p.cmd_code = CODE_A; end
      4: begin p.cmd_class = CLS_LAMP; p.cmd_code = CODE_B; end
      5: begin p.cmd_class = CLS_READ; p.cmd_code = CODE_A; p.len_high = LEN_AXES; end
      6: begin p.cmd_class = CLS_READ; p.cmd_code = CODE_B; p.len_high = LEN_AXES; end
      7: begin p.cmd_class = CLS_READ; p.cmd_code = CODE_C; p.len_high = LEN_TEMP; end
      8: begin p.cmd_class = CLS_READ; p.cmd_code = CODE_D; p.len_high = LEN_AXES; end
      default: begin p.cmd_class = CLS_READ; p.cmd_code = CODE_E; p.len_high = LEN_ALL; end
    endcase
    return p;
  endfunction

  function automatic pkt_t good_pkt(input int sel, input logic [WORD_W-1:0] data);
    pkt_t p;
    p = cmd_frame(sel);
    p.data_word = data;
    p.rx_crc = sb.packet_crc(p);
    return p;
  endfunction

  // mostly well-formed commands, some with broken crc, length or code, the rest noise
  function automatic pkt_t rand_pkt();
    pkt_t p;
    int   kind;
    kind = $urandom_range(99);
    p = good_pkt($urandom_range(9), $urandom);
    if (kind < 20) begin
      p.cmd_class = byte_t'($urandom);
      p.cmd_code  = byte_t'($urandom);
      p.len_high  = byte_t'($urandom);
      p.len_low   = byte_t'($urandom);
      p.rx_crc    = byte_t'($urandom);
    end else if (kind < 32) begin
      p.rx_crc ^= byte_t'($urandom_range(1, 255));
    end else if (kind < 40) begin
      if ($urandom_range(1)) p.len_high ^= byte_t'($urandom_range(1, 255));
      else p.len_low ^= byte_t'($urandom_range(1, 255));
    end else if (kind < 45) begin
      p.cmd_code = byte_t'($urandom);
    end
    return p;
  endfunction

  task automatic send_pkt(input pkt_t p);
    if (!quiet) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_cmd_class <= p.cmd_class;
    in_cmd_code  <= p.cmd_code;
    in_len_high  <= p.len_high;
    in_len_low   <= p.len_low;
    in_data_word <= p.data_word;
    in_rx_crc    <= p.rx_crc;
    do @(posedge clk); while (!in_ready);
    sb.note_input(p);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input byte_t dev, input byte_t poly, input int n_items,
                           input bit no_idle, input bit pressure, input bit stray);
    cfg_write(REG_DEVICE_ID, dev);
    cfg_write(REG_CRC_POLY, poly);
    // writes to unused indexes must leave both registers alone
    if (stray) begin
      cfg_write(REG_SPARE_HI, ~dev);
      cfg_write(REG_SPARE_LO, ~poly);
    end
    cfg_valid <= 1'b0;
    quiet = no_idle;
    if (pressure) hold_req = 1'b1;
    repeat (n_items) send_pkt(rand_pkt());
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    pkt_t p;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd_class <= '0;
    in_cmd_code  <= '0;
    in_len_high  <= '0;
    in_len_low   <= '0;
    in_data_word <= '0;
    in_rx_crc    <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // every command with a good crc, at reset settings
    for (int s = 0; s < 10; s++) begin
      send_pkt(good_pkt(s, (s == 0) ? 32'h0000_0000 :
                            (s == 1) ? 32'hFFFF_FFFF : 32'($urandom)));
    end
    // unknown class
    p = good_pkt(0, $urandom); p.cmd_class = 8'h00; send_pkt(p);
    p = good_pkt(0, $urandom); p.cmd_class = 8'hFF; send_pkt(p);
    p = good_pkt(3, $urandom); p.cmd_class = 8'h04; send_pkt(p);
    // unknown code in a known class
    p = good_pkt(0, $urandom); p.cmd_code = CODE_D; send_pkt(p);
    p = good_pkt(3, $urandom); p.cmd_code = CODE_C; send_pkt(p);
    p = good_pkt(5, $urandom); p.cmd_code = 8'hFF; send_pkt(p);
    p = good_pkt(5, $urandom); p.cmd_code = 8'h00; send_pkt(p);
    // length bytes wrong for the command
    p = good_pkt(0, $urandom); p.len_low = LEN_NONE; send_pkt(p);
    p = good_pkt(1, $urandom); p.len_high = 8'h01; send_pkt(p);
    p = good_pkt(3, $urandom); p.len_high = 8'hFF; send_pkt(p);
    p = good_pkt(7, $urandom); p.len_high = LEN_AXES; send_pkt(p);
    // crc mismatch
    p = good_pkt(2, 32'h8000_0001); p.rx_crc ^= 8'h80; send_pkt(p);
    p = good_pkt(4, $urandom); p.rx_crc ^= 8'h01; send_pkt(p);
    drain();

    run_phase(8'hFF, 8'hFF, 85, 1'b0, 1'b0, 1'b0);
    run_phase(8'h00, 8'h00, 85, 1'b0, 1'b1, 1'b0);
    run_phase(8'hA5, 8'h07, 85, 1'b0, 1'b0, 1'b1);
    run_phase(byte_t'($urandom), byte_t'($urandom), 90, 1'b1, 1'b0, 1'b0);
    run_phase(byte_t'($urandom), byte_t'($urandom), 85, 1'b0, 1'b0, 1'b0);
    run_phase(DEVICE_ID_RESET, CRC_POLY_RESET, 70, 1'b0, 1'b0, 1'b0);

    repeat (20) @(posedge clk);
    if (sb.fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
